// ===== hw/rtl/circular_free_arc_list_unit_macros.svh =====
// Assertion macros for the free arc list engine.
`ifndef CIRCULAR_FREE_ARC_LIST_UNIT_MACROS_SVH
`define CIRCULAR_FREE_ARC_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define CFAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfal: same-cycle check failed");
// Next-cycle implication check.
`define CFAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfal: next-cycle check failed");
`else
`define CFAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CFAL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cfal_pkg.sv =====
// Package with the types, widths and request codes of the free arc list.
`default_nettype none
package cfal_pkg;

  localparam int TURN_BITS    = 16;
  localparam int TURN         = 1 << TURN_BITS;
  localparam int EW           = TURN_BITS + 1;
  localparam int AW           = TURN_BITS + 4;
  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int COORD_W = 18;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int GAP_W   = 8;
  localparam int ENT_W   = 17;

  localparam logic [GAP_W-1:0] MIN_GAP_RST = GAP_W'(1);
  localparam logic signed [AW-1:0] TURN_S = AW'(TURN);

  localparam logic [KIND_W-1:0] REQ_RESET = 2'd0;
  localparam logic [KIND_W-1:0] REQ_SUB   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  req_type;
    logic [COORD_W-1:0] arc_start;
    logic [COORD_W-1:0] arc_end;
    logic [IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] arc_count;
    logic             overflow;
    logic             entry_valid;
    logic [ENT_W-1:0] entry_low;
    logic [ENT_W-1:0] entry_high;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

  typedef struct packed {
    logic [EW-1:0] lo;
    logic [EW-1:0] hi;
  } arc_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cfal_if.sv =====
// Channel interfaces of the free arc list: request, response and configuration.
`default_nettype none
interface cfal_req_if;
  import cfal_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         req_type;
  logic signed [COORD_W-1:0] arc_start;
  logic signed [COORD_W-1:0] arc_end;
  logic [IDX_W-1:0]          read_index;
  modport source (output valid, output req_type, output arc_start, output arc_end,
                  output read_index, input ready);
  modport sink (input valid, input req_type, input arc_start, input arc_end,
                input read_index, output ready);
endinterface

interface cfal_rsp_if;
  import cfal_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] arc_count;
  logic             overflow;
  logic             entry_valid;
  logic [ENT_W-1:0] entry_low;
  logic [ENT_W-1:0] entry_high;
  modport source (output valid, output arc_count, output overflow, output entry_valid,
                  output entry_low, output entry_high, input ready);
  modport sink (input valid, input arc_count, input overflow, input entry_valid,
                input entry_low, input entry_high, output ready);
endinterface

interface cfal_cfg_if;
  import cfal_pkg::*;
  logic             valid;
  logic             ready;
  logic [GAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cfal_engine.sv =====
// Sequencer, arc table memory and state of the free arc list.
`default_nettype none
`include "circular_free_arc_list_unit_macros.svh"
module cfal_engine #(
  parameter int CAPACITY = cfal_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  cfal_pkg::req_t            item,
  input  logic [cfal_pkg::GAP_W-1:0] min_gap,
  input  logic                      take,
  output cfal_pkg::eng_stat_t       stat,
  output cfal_pkg::rsp_t            result
);
  import cfal_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + IDX_W;

  localparam logic [4:0] S_INIT      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_FOLD      = 5'd2;
  localparam logic [4:0] S_CUT0      = 5'd3;
  localparam logic [4:0] S_CHK0      = 5'd4;
  localparam logic [4:0] S_BS_ISSUE  = 5'd5;
  localparam logic [4:0] S_BS_CMP    = 5'd6;
  localparam logic [4:0] S_PROBE     = 5'd7;
  localparam logic [4:0] S_PROBE2    = 5'd8;
  localparam logic [4:0] S_SWEEP     = 5'd9;
  localparam logic [4:0] S_SWEEP_CHK = 5'd10;
  localparam logic [4:0] S_DROP_MV   = 5'd11;
  localparam logic [4:0] S_ADD_RD    = 5'd12;
  localparam logic [4:0] S_ADD_MV    = 5'd13;
  localparam logic [4:0] S_ADD_PUT   = 5'd14;
  localparam logic [4:0] S_NEXT      = 5'd15;
  localparam logic [4:0] S_READ      = 5'd16;
  localparam logic [4:0] S_DONE      = 5'd17;

  // Clamp a reset bound to one turn.
  function automatic logic [EW-1:0] sat_turn(input logic [COORD_W-1:0] v);
    logic signed [AW-1:0] w;
    w = $signed({{(AW-COORD_W){v[COORD_W-1]}}, v});
    if (w[AW-1]) return '0;
    else if (w > TURN_S) return EW'(TURN);
    else return w[EW-1:0];
  endfunction

  arc_t mem [CAPACITY];
  arc_t rd;
  arc_t wd;
  logic we;
  logic [IW-1:0] wa, ra;

  logic [4:0] state, state_next;
  logic [CW-1:0] count, count_next;
  logic ovf, ovf_next;
  logic [1:0] sp, sp_next;
  logic signed [AW-1:0] a, a_next, b, b_next;
  logic signed [AW-1:0] stk_a [2];
  logic signed [AW-1:0] stk_a_next [2];
  logic signed [AW-1:0] stk_b [2];
  logic signed [AW-1:0] stk_b_next [2];
  logic [CW-1:0] lo, lo_next, hi, hi_next, mid, mid_next;
  logic [CW-1:0] pos, pos_next, i, i_next;
  logic [EW-1:0] d_save, d_save_next;
  logic ev, ev_next;
  logic [EW-1:0] elo, elo_next, ehi, ehi_next;

  logic signed [AW-1:0] rd_lo_s, rd_hi_s, gap_s;
  logic [CW:0] cnt_x, pos_p1, i_p1, i_p2, lo_p1, mid_sum;
  logic [CW-1:0] i_m1, i_m2;
  logic [XW-1:0] idx_x, cnt_xx;
  logic [CW+CNT_W-1:0] cnt_w;

  assign rd_lo_s = $signed({{(AW-EW){1'b0}}, rd.lo});
  assign rd_hi_s = $signed({{(AW-EW){1'b0}}, rd.hi});
  assign gap_s   = $signed({{(AW-GAP_W){1'b0}}, min_gap});
  assign cnt_x   = {1'b0, count};
  assign pos_p1  = {1'b0, pos} + (CW+1)'(1);
  assign i_p1    = {1'b0, i} + (CW+1)'(1);
  assign i_p2    = {1'b0, i} + (CW+1)'(2);
  assign lo_p1   = {1'b0, lo} + (CW+1)'(1);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign i_m1    = i - CW'(1);
  assign i_m2    = i - CW'(2);
  assign idx_x   = {{CW{1'b0}}, item.read_index};
  assign cnt_xx  = {{IDX_W{1'b0}}, count};
  assign cnt_w   = {{CNT_W{1'b0}}, count};

  always_comb begin
    state_next  = state;
    count_next  = count;
    ovf_next    = ovf;
    sp_next     = sp;
    a_next      = a;
    b_next      = b;
    stk_a_next  = stk_a;
    stk_b_next  = stk_b;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    pos_next    = pos;
    i_next      = i;
    d_save_next = d_save;
    ev_next     = ev;
    elo_next    = elo;
    ehi_next    = ehi;
    we          = 1'b0;
    wa          = pos[IW-1:0];
    wd          = rd;
    ra          = pos[IW-1:0];
    case (state)
      S_INIT: begin
        we         = 1'b1;
        wa         = '0;
        wd.lo      = '0;
        wd.hi      = EW'(TURN);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ev_next  = 1'b0;
          elo_next = '0;
          ehi_next = '0;
          a_next   = $signed({{(AW-COORD_W){item.arc_start[COORD_W-1]}}, item.arc_start});
          b_next   = $signed({{(AW-COORD_W){item.arc_end[COORD_W-1]}}, item.arc_end});
          sp_next  = '0;
          state_next = S_DONE;
          case (item.req_type)
            REQ_RESET: begin
              we         = 1'b1;
              wa         = '0;
              wd.lo      = sat_turn(item.arc_start);
              wd.hi      = sat_turn(item.arc_end);
              count_next = CW'(1);
            end
            REQ_SUB: begin
              if ($signed(item.arc_start) <= $signed(item.arc_end)) state_next = S_FOLD;
            end
            REQ_READ: begin
              if ((idx_x < cnt_xx) && (idx_x < XW'(CAPACITY))) begin
                ra         = idx_x[IW-1:0];
                state_next = S_READ;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_READ: begin
        ev_next    = 1'b1;
        elo_next   = rd.lo;
        ehi_next   = rd.hi;
        state_next = S_DONE;
      end
      S_FOLD: begin
        // One folding rule per cycle; pending pieces wait on a two-deep stack.
        if (a > TURN_S) begin
          a_next = a - TURN_S;
          b_next = b - TURN_S;
        end else if (b[AW-1]) begin
          a_next = a + TURN_S;
          b_next = b + TURN_S;
        end else if (a[AW-1]) begin
          stk_a_next[sp[0]] = a + TURN_S;
          stk_b_next[sp[0]] = TURN_S;
          sp_next = sp + 2'd1;
          a_next  = '0;
        end else if (b > TURN_S) begin
          stk_a_next[sp[0]] = '0;
          stk_b_next[sp[0]] = b - TURN_S;
          sp_next = sp + 2'd1;
          b_next  = TURN_S;
        end else begin
          state_next = S_CUT0;
        end
      end
      S_CUT0: begin
        if (count == '0) begin
          state_next = S_NEXT;
        end else begin
          ra         = '0;
          state_next = S_CHK0;
        end
      end
      S_CHK0: begin
        if (a < rd_lo_s) begin
          pos_next   = '0;
          state_next = S_SWEEP;
        end else begin
          lo_next    = '0;
          hi_next    = count;
          state_next = S_BS_ISSUE;
        end
      end
      S_BS_ISSUE: begin
        if (lo_p1 < {1'b0, hi}) begin
          mid_next   = mid_sum[CW:1];
          ra         = mid_sum[IW:1];
          state_next = S_BS_CMP;
        end else begin
          pos_next   = lo;
          ra         = lo[IW-1:0];
          state_next = S_PROBE;
        end
      end
      S_BS_CMP: begin
        if (rd_lo_s < a) lo_next = mid;
        else hi_next = mid;
        state_next = S_BS_ISSUE;
      end
      S_PROBE: begin
        if (a < rd_hi_s) begin
          if ((a - rd_lo_s) < gap_s) begin
            if (b < rd_hi_s) begin
              we         = 1'b1;
              wd.lo      = b[EW-1:0];
              state_next = S_NEXT;
            end else begin
              i_next = pos;
              if (pos_p1 < cnt_x) begin
                ra         = pos_p1[IW-1:0];
                state_next = S_DROP_MV;
              end else begin
                count_next = count - CW'(1);
                state_next = S_SWEEP;
              end
            end
          end else begin
            we          = 1'b1;
            wd.hi       = a[EW-1:0];
            pos_next    = pos_p1[CW-1:0];
            d_save_next = rd.hi;
            state_next  = S_SWEEP;
            if (b < rd_hi_s) begin
              if (count >= CW'(CAPACITY)) begin
                ovf_next = 1'b1;
              end else begin
                i_next     = count;
                state_next = S_ADD_RD;
              end
            end
          end
        end else if (pos_p1 < cnt_x) begin
          ra         = pos_p1[IW-1:0];
          state_next = S_PROBE2;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_PROBE2: begin
        if (b > rd_lo_s) begin
          pos_next   = pos_p1[CW-1:0];
          state_next = S_SWEEP;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_SWEEP: begin
        if (pos < count) begin
          ra         = pos[IW-1:0];
          state_next = S_SWEEP_CHK;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_SWEEP_CHK: begin
        state_next = S_NEXT;
        if (b > rd_lo_s) begin
          if ((rd_hi_s - b) < gap_s) begin
            i_next = pos;
            if (pos_p1 < cnt_x) begin
              ra         = pos_p1[IW-1:0];
              state_next = S_DROP_MV;
            end else begin
              count_next = count - CW'(1);
              state_next = S_SWEEP;
            end
          end else begin
            we    = 1'b1;
            wd.lo = b[EW-1:0];
          end
        end
      end
      S_DROP_MV: begin
        // Move entry i+1 down while entry i+2 is fetched.
        we     = 1'b1;
        wa     = i[IW-1:0];
        wd     = rd;
        i_next = i_p1[CW-1:0];
        if (i_p2 < cnt_x) begin
          ra = i_p2[IW-1:0];
        end else begin
          count_next = count - CW'(1);
          state_next = S_SWEEP;
        end
      end
      S_ADD_RD: begin
        if (i > pos) begin
          ra         = i_m1[IW-1:0];
          state_next = S_ADD_MV;
        end else begin
          state_next = S_ADD_PUT;
        end
      end
      S_ADD_MV: begin
        we     = 1'b1;
        wa     = i[IW-1:0];
        wd     = rd;
        i_next = i_m1;
        if (i_m1 > pos) ra = i_m2[IW-1:0];
        else state_next = S_ADD_PUT;
      end
      S_ADD_PUT: begin
        we         = 1'b1;
        wd.lo      = b[EW-1:0];
        wd.hi      = d_save;
        count_next = count + CW'(1);
        state_next = S_SWEEP;
      end
      S_NEXT: begin
        if (sp != 2'd0) begin
          a_next     = stk_a[~sp[0]];
          b_next     = stk_b[~sp[0]];
          sp_next    = sp - 2'd1;
          state_next = S_FOLD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      count <= CW'(1);
      ovf   <= 1'b0;
      sp    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    a      <= a_next;
    b      <= b_next;
    stk_a  <= stk_a_next;
    stk_b  <= stk_b_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    pos    <= pos_next;
    i      <= i_next;
    d_save <= d_save_next;
    ev     <= ev_next;
    elo    <= elo_next;
    ehi    <= ehi_next;
  end

  assign stat.idle          = (state == S_IDLE);
  assign stat.done          = (state == S_DONE);
  assign result.arc_count   = cnt_w[CNT_W-1:0];
  assign result.overflow    = ovf;
  assign result.entry_valid = ev;
  assign result.entry_low   = elo;
  assign result.entry_high  = ehi;

  `CFAL_ASSERT_NXT(a_ovf_sticky, clk, rst, ovf, ovf)
  `CFAL_ASSERT_NXT(a_idle_holds, clk, rst, (state == S_IDLE) && !start, $stable(count) && $stable(ovf))
  `CFAL_ASSERT_IMP(a_cnt_bound, clk, rst, state != S_INIT, count <= CW'(CAPACITY))
  `CFAL_ASSERT_IMP(a_stack_depth, clk, rst, state == S_FOLD, sp <= 2'd2)

endmodule
`default_nettype wire

// ===== hw/rtl/circular_free_arc_list_unit.sv =====
// Top level of the circular free arc list with its channels and result register.
// The block keeps a sorted table of disjoint free arcs on one turn of 65536 units.
// Requests arrive on req: a reset item loads one arc, a subtract item removes an
// arc (folded onto one turn and split at zero), and a read item returns one entry.
// Every item gives exactly one result item on rsp with the arc count, the sticky
// overflow flag and, for reads, the entry. The min_gap register is written on cfg,
// which is always ready, and must only change while the block is idle.
// A reset item goes straight to its result; a read item first fetches the entry. A
// subtract item runs a fold step per cycle, then for each of up to four pieces a
// binary search over the table (each step one memory read and a compare) and a
// shift of entries at one per cycle. Each arc that a cut deletes costs its own
// shift of the tail through the single read and write port of the arc table.
// One item is worked on at a time and req is not ready meanwhile.
// A finished result sits in an output register, so the next item is taken while
// the receiver stalls; a second finished result then waits inside the engine.
// After reset the table is re-seeded with the full turn in the init state, during which
// req is not ready; the overflow flag clears only on reset.
`default_nettype none
module circular_free_arc_list_unit #(
  parameter int CAPACITY = cfal_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  cfal_req_if.sink   req,
  cfal_rsp_if.source rsp,
  cfal_cfg_if.sink   cfg
);
  import cfal_pkg::*;

  logic [GAP_W-1:0] min_gap;
  req_t             item;
  eng_stat_t        stat;
  rsp_t             eng_rsp;
  rsp_t             rsp_data;
  logic             rsp_full;
  logic             start;
  logic             take;

  // The gap register is always open to writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= MIN_GAP_RST;
    end else if (cfg.valid && cfg.ready) begin
      min_gap <= cfg.data;
    end
  end

  always_comb begin
    item.req_type   = req.req_type;
    item.arc_start  = req.arc_start;
    item.arc_end    = req.arc_end;
    item.read_index = req.read_index;
  end

  assign req.ready = stat.idle;
  assign start     = req.valid && req.ready;

  // The engine hands over its result whenever the output register is free or
  // is being emptied in this very cycle.
  assign take = stat.done && (!rsp_full || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (take) begin
      rsp_full <= 1'b1;
    end else if (rsp.ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rsp_data <= eng_rsp;
  end

  assign rsp.valid       = rsp_full;
  assign rsp.arc_count   = rsp_data.arc_count;
  assign rsp.overflow    = rsp_data.overflow;
  assign rsp.entry_valid = rsp_data.entry_valid;
  assign rsp.entry_low   = rsp_data.entry_low;
  assign rsp.entry_high  = rsp_data.entry_high;

  cfal_engine #(
    .CAPACITY(CAPACITY)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .min_gap(min_gap),
    .take   (take),
    .stat   (stat),
    .result (eng_rsp)
  );

endmodule
`default_nettype wire

// ===== test/circular_free_arc_list_unit_checker.sv =====
// Checker for the free arc list: keeps its own arc table, predicts every result and compares.
module circular_free_arc_list_unit_checker
  import cfal_pkg::*;
(
  input  logic clk,
  input  logic rst,
  cfal_req_if  req,
  cfal_rsp_if  rsp,
  cfal_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  logic [ENT_W-1:0] arc_lo [CAPACITY_DEF];
  logic [ENT_W-1:0] arc_hi [CAPACITY_DEF];
  int               arcs;
  bit               full_hit;
  logic [GAP_W-1:0] gap;
  rsp_t             awaited_rsp [$];
  int               errors = 0;
  int               backlog = 0;

  assign fail_count = errors;
  assign pending    = backlog;

  task automatic report(string field, int got, int want);
    $display("cfal mismatch at %0t: %s is %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  function automatic int clamp_turn(int v);
    if (v < 0) return 0;
    if (v > TURN) return TURN;
    return v;
  endfunction

  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < arcs; i++) begin
      arc_lo[i] = arc_lo[i+1];
      arc_hi[i] = arc_hi[i+1];
    end
    arcs--;
  endfunction

  // A split on a full table loses its upper piece and raises the sticky flag.
  function automatic void insert_slot(int pos, int lo, int hi);
    if (arcs >= CAPACITY_DEF) begin
      full_hit = 1'b1;
      return;
    end
    for (int i = arcs; i > pos; i--) begin
      arc_lo[i] = arc_lo[i-1];
      arc_hi[i] = arc_hi[i-1];
    end
    arc_lo[pos] = ENT_W'(lo);
    arc_hi[pos] = ENT_W'(hi);
    arcs++;
  endfunction

  // Removes [a, b] with both ends inside one turn.
  function automatic void carve(int a, int b);
    int pos, lo, hi, mid, c, d, g;
    g = int'(gap);
    if (arcs == 0) return;
    if (a < int'(arc_lo[0])) begin
      pos = 0;
    end else begin
      lo = 0;
      hi = arcs;
      while (lo < hi - 1) begin
        mid = (lo + hi) >> 1;
        if (int'(arc_lo[mid]) < a) lo = mid;
        else hi = mid;
      end
      pos = lo;
      if (a < int'(arc_hi[pos])) begin
        c = int'(arc_lo[pos]);
        d = int'(arc_hi[pos]);
        if (a - c < g) begin
          if (b < d) arc_lo[pos] = ENT_W'(b);
          else remove_slot(pos);
        end else begin
          arc_hi[pos] = ENT_W'(a);
          if (b < d) insert_slot(pos + 1, b, d);
          pos++;
        end
      end else if (pos < arcs - 1 && b > int'(arc_lo[pos+1])) begin
        pos++;
      end else begin
        return;
      end
    end
    while (pos < arcs && b > int'(arc_lo[pos])) begin
      if (int'(arc_hi[pos]) - b < g) remove_slot(pos);
      else arc_lo[pos] = ENT_W'(b);
    end
  endfunction

  // Folds [a, b] onto one turn; pieces are handled depth first, last pushed piece first.
  function automatic void subtract_folded(int a, int b);
    int sa [$];
    int sb [$];
    int x, y;
    sa.push_back(a);
    sb.push_back(b);
    while (sa.size() > 0) begin
      x = sa.pop_back();
      y = sb.pop_back();
      if (x > TURN) begin
        sa.push_back(x - TURN); sb.push_back(y - TURN);
      end else if (y < 0) begin
        sa.push_back(x + TURN); sb.push_back(y + TURN);
      end else if (x < 0) begin
        sa.push_back(x + TURN); sb.push_back(TURN);
        sa.push_back(0);        sb.push_back(y);
      end else if (y > TURN) begin
        sa.push_back(0);        sb.push_back(y - TURN);
        sa.push_back(x);        sb.push_back(TURN);
      end else begin
        carve(x, y);
      end
    end
  endfunction

  function automatic rsp_t table_after_request(logic [KIND_W-1:0] kind, int a, int b, int idx);
    rsp_t r;
    r = '0;
    case (kind)
      REQ_RESET: begin
        arc_lo[0] = ENT_W'(clamp_turn(a));
        arc_hi[0] = ENT_W'(clamp_turn(b));
        arcs = 1;
      end
      REQ_SUB: begin
        if (a <= b) subtract_folded(a, b);
      end
      REQ_READ: begin
        if (idx < arcs) begin
          r.entry_valid = 1'b1;
          r.entry_low   = arc_lo[idx];
          r.entry_high  = arc_hi[idx];
        end
      end
      default: ;
    endcase
    r.arc_count = CNT_W'(arcs);
    r.overflow  = full_hit;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t seen, want;
    if (rst) begin
      for (int i = 0; i < CAPACITY_DEF; i++) begin
        arc_lo[i] = '0;
        arc_hi[i] = '0;
      end
      arc_hi[0] = ENT_W'(TURN);
      arcs      = 1;
      full_hit  = 1'b0;
      gap       = MIN_GAP_RST;
      awaited_rsp.delete();
    end else begin
      if (cfg.valid && cfg.ready) gap = cfg.data;
      if (req.valid && req.ready) begin
        awaited_rsp.push_back(table_after_request(req.req_type, int'($signed(req.arc_start)),
                                                  int'($signed(req.arc_end)),
                                                  int'(req.read_index)));
      end
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.arc_count, rsp.overflow, rsp.entry_valid, rsp.entry_low, rsp.entry_high};
        if (awaited_rsp.size() == 0) begin
          report("unexpected result, arc_count", seen.arc_count, 0);
        end else begin
          want = awaited_rsp.pop_front();
          if (seen.arc_count !== want.arc_count)
            report("arc_count", seen.arc_count, want.arc_count);
          if (seen.overflow !== want.overflow)
            report("overflow", seen.overflow, want.overflow);
          if (seen.entry_valid !== want.entry_valid)
            report("entry_valid", seen.entry_valid, want.entry_valid);
          if (seen.entry_low !== want.entry_low)
            report("entry_low", seen.entry_low, want.entry_low);
          if (seen.entry_high !== want.entry_high)
            report("entry_high", seen.entry_high, want.entry_high);
        end
      end
    end
    backlog <= awaited_rsp.size();
  end

endmodule

// ===== test/circular_free_arc_list_unit_tb.sv =====
// Testbench top for the free arc list: clock, reset, stimulus, result stalls and the verdict.
module circular_free_arc_list_unit_tb;
  import cfal_pkg::*;

  // The slowest correct run stays far below this, even with four pieces per subtract,
  // a full shift each and every receiver stall.
  localparam int CYCLE_LIMIT  = 5000000;
  localparam int STAGE_ITEMS  = 305;
  localparam int STALL_AT     = 450;
  localparam int STALL_CYCLES = 400;

  // A request type with no meaning, which the block must ignore.
  localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   useful = 0;
  int   cycle_count = 0;
  bit   steady = 1'b0;
  bit   stall_done = 1'b0;

  cfal_req_if req_ch ();
  cfal_rsp_if rsp_ch ();
  cfal_cfg_if cfg_ch ();

  circular_free_arc_list_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  circular_free_arc_list_unit_checker arc_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hang: a lost result or a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_free_arc_list_unit_tb NOT OK");
      $finish;
    end
  end

  // Result side. It mostly takes items at random, but once, part way through the
  // run, it refuses everything for a long stretch while the sender keeps offering
  // items, so that the output register and the engine both fill and req stalls.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!stall_done && items_sent >= STALL_AT) begin
        stall_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        for (int n = 0; n < STALL_CYCLES; n++) @(posedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= 24);
    end
  end

  // A random 18-bit coordinate over the whole two's complement range.
  function automatic int raw_coord();
    return int'($signed(COORD_W'($urandom)));
  endfunction

  // Offers one item, idling first at random, and returns at the edge that takes it.
  // The valid line is left high so that a following item can go out without a gap.
  task automatic send(logic [KIND_W-1:0] kind, int a, int b, int idx);
    if (!steady) begin
      while ($urandom_range(99) < 24) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.arc_start  <= COORD_W'(a);
    req_ch.arc_end    <= COORD_W'(b);
    req_ch.read_index <= IDX_W'(idx);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Lowers valid and waits until every result has come back. The first edge lets
  // the checker record the item taken at the edge just passed.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_gap(int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= GAP_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random operation on a loaded table. Most are subtracts, mostly short, at random
  // places, so the table fragments, fills and eventually overflows; some cross
  // zero or lie whole turns away, and a few carry fully random coordinates.
  task automatic random_op();
    int r, a, b, c, len, t;
    r = $urandom_range(99);
    if (r < 58) begin
      len = ($urandom_range(99) < 70) ? $urandom_range(1500) : $urandom_range(40000);
      c = $urandom_range(TURN);
      if ($urandom_range(9) == 0) c = TURN - $urandom_range(800);
      a = c;
      b = c + len;
      case ($urandom_range(9))
        0: begin a -= TURN;     b -= TURN;     end
        1: begin a += TURN;     b += TURN;     end
        2: begin a -= 2 * TURN; b -= 2 * TURN; end
        default: ;
      endcase
      if (b > 131071) b = 131071;
      if (a > 131071) a = 131071;
      send(REQ_SUB, a, b, $urandom_range(15));
      useful++;
    end else if (r < 64) begin
      a = raw_coord();
      b = raw_coord();
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      send(REQ_SUB, a, b, $urandom_range(15));
      useful++;
    end else if (r < 94) begin
      send(REQ_READ, raw_coord(), raw_coord(), $urandom_range(15));
      useful++;
    end else if (r < 97) begin
      send(REQ_UNUSED, raw_coord(), raw_coord(), $urandom_range(15));
    end else begin
      // An empty arc, start beyond end, which the block leaves alone.
      a = $urandom_range(1, TURN);
      send(REQ_SUB, a, a - $urandom_range(1, 3000), $urandom_range(15));
    end
  endtask

  // A well-formed run of work: load the table, then operate on it for a while.
  task automatic random_episode();
    int r, a, n;
    r = $urandom_range(99);
    if (r < 70) begin
      send(REQ_RESET, 0, TURN, $urandom_range(15));
    end else if (r < 88) begin
      a = $urandom_range(TURN);
      send(REQ_RESET, a, a + $urandom_range(TURN - a), $urandom_range(15));
    end else begin
      send(REQ_RESET, raw_coord(), raw_coord(), $urandom_range(15));
    end
    useful++;
    n = $urandom_range(4, 40);
    repeat (n) random_op();
  endtask

  initial begin
    int gap_plan [5] = '{0, 255, 1, 17, 3};
    int goal;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_READ;
    req_ch.arc_start  <= '0;
    req_ch.arc_end    <= '0;
    req_ch.read_index <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the gap at its reset value of one.
    send(REQ_READ, 0, 0, 0);                  // the full turn after reset
    send(REQ_READ, 0, 0, 15);                 // index beyond the count
    send(REQ_UNUSED, -1, 0, 15);              // unused request type
    send(REQ_SUB, 500, 100, 0);               // start above end: empty arc
    send(REQ_SUB, 1000, 2000, 0);             // split in the middle
    send(REQ_READ, 0, 0, 1);
    send(REQ_SUB, 0, 50, 0);                  // trims the low end
    send(REQ_SUB, -500, 300, 0);              // crosses zero
    send(REQ_SUB, 65000, 66000, 0);           // crosses the end of the turn
    send(REQ_SUB, 70000, 71000, 0);           // lies wholly beyond one turn
    send(REQ_SUB, -131072, -130000, 0);       // two turns below zero
    send(REQ_READ, 0, 0, 0);
    send(REQ_SUB, 100, 100, 0);               // zero-length cut
    send(REQ_SUB, 65536, 65536, 0);           // cut at the very end
    send(REQ_SUB, -131072, 131071, 0);        // removes everything
    send(REQ_SUB, 10, 20, 0);                 // subtract on an empty table
    send(REQ_READ, 0, 0, 0);                  // read on an empty table
    send(REQ_RESET, -5, 131071, 0);           // out of range, saturates
    send(REQ_READ, 0, 0, 0);
    send(REQ_RESET, 131071, -131072, 0);      // low above high, saturated but not reordered
    send(REQ_READ, 0, 0, 0);
    send(REQ_SUB, 200, 300, 0);
    send(REQ_RESET, 0, TURN, 0);
    send(REQ_READ, 0, 0, 0);

    // Random stages, each under its own gap setting. The middle stage runs with
    // no idling on either side.
    for (int s = 0; s < 5; s++) begin
      drain();
      write_gap(gap_plan[s]);
      steady = (s == 2);
      goal = useful + STAGE_ITEMS;
      while (useful < goal) random_episode();
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("circular_free_arc_list_unit_tb OK");
    end else begin
      $display("circular_free_arc_list_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
